[rtl/core/gdbrsp_pkg.sv]
// Package with the types, constants and the helper function of the packet deframer.
package gdbrsp_pkg;

   // Payload length bound (a packet carries at most MAX_PAYLOAD - 1 bytes) and the counter width that can hold it.
   localparam int unsigned MAX_PAYLOAD = 1024;
   localparam int unsigned COUNT_W     = $clog2(MAX_PAYLOAD + 1);

   // Idle tick limit register.
   localparam int unsigned LIMIT_W     = 16;
   localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = LIMIT_W'(100);

   // Framing characters.
   localparam logic [7:0] START_MARK = 8'h24;
   localparam logic [7:0] END_MARK   = 8'h23;

   // Input command codes.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Verdict codes.
   typedef enum logic [1:0] {
      VERDICT_OK       = 2'd0,
      VERDICT_MISMATCH = 2'd1,
      VERDICT_TOO_LONG = 2'd2,
      VERDICT_TIMEOUT  = 2'd3
   } verdict_type;

   // Deframer phases.
   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_DATA  = 2'd1,
      PH_CK_HI = 2'd2,
      PH_CK_LO = 2'd3
   } phase_type;

   // Value of a hex digit in bits 3:0; bit 4 is set when the byte is not hex.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      v = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = {1'b0, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = {1'b0, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = {1'b0, 4'(b - 8'h37)};
      end
      return v;
   endfunction

endpackage

[rtl/core/gdb_rsp_packet_deframer.sv]
// Top level of the serial protocol packet deframer with checksum verdicts.
//
// The deframer takes one transaction per clock cycle while the result side
// keeps up: a received byte or an idle tick. Each transaction is captured
// in an input register, processed combinationally against the framing
// state and, if it gives a result, placed in an output register. Payload
// bytes between '$' and '#' are passed through as they arrive and summed
// modulo 256; after the two checksum digits one verdict follows (good or
// checksum mismatch), and a packet that runs too long or times out ends
// with a too-long or timeout verdict instead. Downstream should discard the
// payload of a packet whose verdict is not good. The idle tick limit is to
// be written through the csr_ port only while no transaction is in flight;
// the block does not enforce this. csr_ready is always high.
module gdb_rsp_packet_deframer (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gdbrsp_pkg::LIMIT_W-1:0] csr_idle_tick_limit,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [7:0]                     req_rx_byte,
   // Response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_out_kind,
   output logic [7:0]                     rsp_payload_byte,
   output logic                           rsp_packet_good,
   output logic [1:0]                     rsp_verdict_code
);
   import gdbrsp_pkg::*;

   // Configuration register
   logic [LIMIT_W-1:0] idle_limit_ff;

   // Input register
   logic               in_valid_ff, in_valid_in;
   logic               in_cmd_ff;
   logic [7:0]         in_byte_ff;

   // Framing state
   phase_type          phase_ff, phase_in;
   logic [7:0]         sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [4:0]         high_ff, high_in;
   logic [LIMIT_W-1:0] idle_ff, idle_in;

   // Result of the current transaction
   logic               res_valid;
   logic               res_kind;
   verdict_type        res_verdict;

   // Output register
   logic               out_valid_ff, out_valid_in;
   logic               out_kind_ff;
   logic [7:0]         out_byte_ff;
   logic               out_good_ff;
   verdict_type        out_verdict_ff;

   logic               advance;
   logic               step;
   logic [4:0]         low_digit;
   logic               ck_ok;
   logic               too_long;
   logic               timed_out;

   // The processing stage moves when the output register is empty or drained.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = advance && in_valid_ff;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   // Configuration register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IDLE_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         idle_limit_ff <= csr_idle_tick_limit;
      end
   end

   // Input register: loads on an accepted transaction.
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_rx_byte;
      end
   end

   // Decoded conditions of the current transaction.
   assign low_digit = hex_value(in_byte_ff);
   assign ck_ok     = !high_ff[4] && !low_digit[4] && ({high_ff[3:0], low_digit[3:0]} == sum_ff);
   assign too_long  = count_ff >= COUNT_W'(MAX_PAYLOAD - 1);
   assign timed_out = idle_ff >= idle_limit_ff;

   // Next state of the framing logic.
   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      high_in  = high_ff;
      idle_in  = idle_ff;
      if (in_cmd_ff == CMD_TICK) begin
         if (phase_ff != PH_HUNT) begin
            if (timed_out) begin
               phase_in = PH_HUNT;
               idle_in  = '0;
            end else begin
               idle_in  = idle_ff + LIMIT_W'(1);
            end
         end
      end else begin
         idle_in = '0;
         unique case (phase_ff)
            PH_HUNT: begin
               if (in_byte_ff == START_MARK) begin
                  phase_in = PH_DATA;
                  sum_in   = '0;
                  count_in = '0;
                  high_in  = '0;
               end
            end
            PH_DATA: begin
               if (in_byte_ff == END_MARK) begin
                  phase_in = PH_CK_HI;
               end else if (too_long) begin
                  phase_in = PH_HUNT;
               end else begin
                  count_in = count_ff + COUNT_W'(1);
                  sum_in   = sum_ff + in_byte_ff;
               end
            end
            PH_CK_HI: begin
               high_in  = hex_value(in_byte_ff);
               phase_in = PH_CK_LO;
            end
            PH_CK_LO: begin
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // Result of the current transaction.
   always_comb begin
      res_valid   = 1'b0;
      res_kind    = KIND_PAYLOAD;
      res_verdict = VERDICT_OK;
      if (in_cmd_ff == CMD_TICK) begin
         if (phase_ff != PH_HUNT && timed_out) begin
            res_valid   = 1'b1;
            res_kind    = KIND_VERDICT;
            res_verdict = VERDICT_TIMEOUT;
         end
      end else begin
         unique case (phase_ff)
            PH_DATA: begin
               if (in_byte_ff != END_MARK) begin
                  res_valid = 1'b1;
                  if (too_long) begin
                     res_kind    = KIND_VERDICT;
                     res_verdict = VERDICT_TOO_LONG;
                  end
               end
            end
            PH_CK_LO: begin
               res_valid   = 1'b1;
               res_kind    = KIND_VERDICT;
               res_verdict = ck_ok ? VERDICT_OK : VERDICT_MISMATCH;
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   // Framing state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         sum_ff   <= '0;
         count_ff <= '0;
         high_ff  <= '0;
         idle_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         high_ff  <= high_in;
         idle_ff  <= idle_in;
      end
   end

   // Output register.
   assign out_valid_in = advance ? (in_valid_ff && res_valid) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         out_kind_ff    <= res_kind;
         out_byte_ff    <= (res_kind == KIND_PAYLOAD) ? in_byte_ff : 8'h00;
         out_good_ff    <= (res_kind == KIND_VERDICT) && (res_verdict == VERDICT_OK);
         out_verdict_ff <= res_verdict;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_kind     = out_kind_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_packet_good  = out_good_ff;
   assign rsp_verdict_code = out_verdict_ff;

endmodule

[rtl/core/gdbrsp_checker.sv]
// Port checker for the packet deframer, bound to the top level.
module gdbrsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_out_kind,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_packet_good,
   input logic [1:0] rsp_verdict_code
);
   import gdbrsp_pkg::*;

   // A payload transaction carries no verdict information.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == KIND_PAYLOAD) |->
         (!rsp_packet_good && rsp_verdict_code == VERDICT_OK))
      else $error("payload transaction carries verdict fields");

   // A verdict is good exactly when its code says the checksum matched, and its byte is zero.
   a_good_matches_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == KIND_VERDICT) |->
         (rsp_packet_good == (rsp_verdict_code == VERDICT_OK)) && rsp_payload_byte == 8'h00)
      else $error("verdict good flag disagrees with its code");

   // A new result after an empty output follows an accepted request, through the input and output registers.
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result appeared without a matching request");

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_kind) &&
         $stable(rsp_payload_byte) && $stable(rsp_verdict_code)))
      else $error("stalled response changed");

endmodule

bind gdb_rsp_packet_deframer gdbrsp_checker u_gdbrsp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_kind     (rsp_out_kind),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_packet_good  (rsp_packet_good),
   .rsp_verdict_code (rsp_verdict_code)
);
